// File: rtl/core/lebc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lebc_pkg
// Shared types and constants for the 32-bit LEB128 codec: operation codes,
// result kinds, queue geometry and the queue entry layout.
// ----------------------------------------------------------------------------
package lebc_pkg;

	// operation codes on the input channel
	typedef enum logic [1:0] {
		OP_DEC_U = 2'd0,
		OP_DEC_S = 2'd1,
		OP_ENC   = 2'd2
	} op_t;

	// result kinds on the output channel
	localparam logic KIND_VALUE = 1'b0;
	localparam logic KIND_BYTE  = 1'b1;

	// leb128 framing
	localparam logic [7:0] GROUP_MASK = 8'h7f;
	localparam logic [7:0] CONT_BIT   = 8'h80;
	localparam logic [2:0] MAX_BYTES  = 3'd5;
	localparam logic [2:0] LAST_IDX   = 3'd4;

	// queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// one classified item as it travels from front to back
	typedef struct packed {
		op_t         op;
		logic [7:0]  data_byte;
		logic [31:0] word;
	} entry_t;

endpackage

// File: rtl/core/leb128_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb128_codec
// 32-bit LEB128 codec: decodes unsigned or signed byte streams into values
// and encodes 32-bit words into 1 to 5 bytes.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------------------
//  input   | in_valid / in_ready   | operation, data_byte, word
//  output  | out_valid / out_ready | kind, decoded_value, encoded_byte,
//          |                       | length, last
//
// the back takes decode bytes one at a time; an encode word yields 1 to 5
// bytes from the encode sequencer, which emits one byte per cycle unless the
// output stalls. a two-item queue decouples input acceptance from execution.
// reset clears the queue, decode state, sequencer and output valid at once.
// a stalled output holds the result register; the queue keeps accepting
// until full, and intermediate decode bytes retire even while output stalls.
module leb128_codec import lebc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [7:0]  data_byte,
	input  logic [31:0] word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [31:0] decoded_value,
	output logic [7:0]  encoded_byte,
	output logic [2:0]  length,
	output logic        last
);

	logic   q_valid;
	logic   q_pop;
	entry_t q_entry;

	// accept and classify items
	lebc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.data_byte (data_byte),
		.word      (word),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop)
	);

	// decode and encode execution
	lebc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_entry       (q_entry),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.decoded_value (decoded_value),
		.encoded_byte  (encoded_byte),
		.length        (length),
		.last          (last)
	);

endmodule

// File: rtl/core/lebc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lebc_front
// Input side: accepts items, drops the unused operation code and queues the
// rest for the execution side in a small fifo.
// ----------------------------------------------------------------------------
module lebc_front import lebc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [7:0]  data_byte,
	input  logic [31:0] word,
	output logic        q_valid,
	output entry_t      q_entry,
	input  logic        q_pop
);

	entry_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                accept;
	logic                push;
	logic                pop;
	logic                known_op;

	// classify: only decode and encode codes enter the queue
	assign known_op = (operation == OP_DEC_U) || (operation == OP_DEC_S) ||
		(operation == OP_ENC);

	assign in_ready = (count_q != QCNT_W'(QDEPTH));
	assign accept   = in_valid && in_ready;
	assign push     = accept && known_op;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_entry  = mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q].op        <= op_t'(operation);
			mem_q[wr_ptr_q].data_byte <= data_byte;
			mem_q[wr_ptr_q].word      <= word;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/core/lebc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lebc_back
// Execution side: builds decoded values byte by byte, splits encode words into
// bytes one per cycle unless output stalls; results sit in an output register.
// ----------------------------------------------------------------------------
module lebc_back import lebc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  entry_t      q_entry,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [31:0] decoded_value,
	output logic [7:0]  encoded_byte,
	output logic [2:0]  length,
	output logic        last
);

	// decode state
	logic [31:0] acc_q;
	logic [2:0]  seen_q;
	logic        signed_q;
	// encode sequencer
	logic        enc_busy_q;
	logic [31:0] enc_rem_q;
	// output register
	logic        out_valid_q;
	logic        kind_q;
	logic [31:0] value_q;
	logic [7:0]  byte_q;
	logic [2:0]  len_q;
	logic        last_q;

	logic        slot_free;
	logic        is_enc;
	logic        dec_done;
	logic        dec_sgn;
	logic [2:0]  dec_len;
	logic [31:0] dec_part;
	logic [31:0] dec_acc;
	logic [31:0] dec_val;
	logic [31:0] enc_src;
	logic [31:0] enc_rest;
	logic [7:0]  enc_byte;
	logic        enc_emit;
	logic        dec_emit;

	assign slot_free = !out_valid_q || out_ready;
	assign is_enc    = (q_entry.op == OP_ENC);

	// place the byte's group at its position
	always_comb begin
		case (seen_q)
			3'd0:    dec_part = {25'd0, q_entry.data_byte[6:0]};
			3'd1:    dec_part = {18'd0, q_entry.data_byte[6:0], 7'd0};
			3'd2:    dec_part = {11'd0, q_entry.data_byte[6:0], 14'd0};
			3'd3:    dec_part = {4'd0, q_entry.data_byte[6:0], 21'd0};
			default: dec_part = {q_entry.data_byte[3:0], 28'd0};
		endcase
	end

	assign dec_acc  = acc_q | dec_part;
	assign dec_len  = seen_q + 3'd1;
	assign dec_done = (seen_q >= LAST_IDX) || ((q_entry.data_byte & CONT_BIT) == 8'd0);
	assign dec_sgn  = (seen_q == 3'd0) ? (q_entry.op == OP_DEC_S) : signed_q;

	// sign extension from the top group bit for values shorter than five bytes
	always_comb begin
		if (!dec_sgn) begin
			dec_val = dec_acc;
		end else begin
			case (dec_len)
				3'd1:    dec_val = {{25{dec_acc[6]}}, dec_acc[6:0]};
				3'd2:    dec_val = {{18{dec_acc[13]}}, dec_acc[13:0]};
				3'd3:    dec_val = {{11{dec_acc[20]}}, dec_acc[20:0]};
				3'd4:    dec_val = {{4{dec_acc[27]}}, dec_acc[27:0]};
				default: dec_val = dec_acc;
			endcase
		end
	end

	// next encoded byte from the pending word or from a fresh entry
	assign enc_src  = enc_busy_q ? enc_rem_q : q_entry.word;
	assign enc_rest = enc_src >> 7;
	assign enc_byte = (enc_src[7:0] & GROUP_MASK) | ((enc_rest != '0) ? CONT_BIT : 8'd0);

	// the encode sequencer owns the back until its last byte goes out
	assign q_pop    = !enc_busy_q && q_valid && (slot_free || (!is_enc && !dec_done));
	assign enc_emit = slot_free && (enc_busy_q || (q_pop && is_enc));
	assign dec_emit = q_pop && !is_enc && dec_done;

	// decode state and encode sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			seen_q     <= '0;
			signed_q   <= 1'b0;
			enc_busy_q <= 1'b0;
		end else begin
			if (q_pop && !is_enc) begin
				signed_q <= dec_sgn;
				if (dec_done) begin
					acc_q  <= '0;
					seen_q <= '0;
				end else begin
					acc_q  <= dec_acc;
					seen_q <= dec_len;
				end
			end
			if (enc_emit) begin
				enc_busy_q <= (enc_rest != '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enc_emit) begin
			enc_rem_q <= enc_rest;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (enc_emit || dec_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (enc_emit) begin
			kind_q  <= KIND_BYTE;
			value_q <= '0;
			byte_q  <= enc_byte;
			len_q   <= '0;
			last_q  <= (enc_rest == '0);
		end else if (dec_emit) begin
			kind_q  <= KIND_VALUE;
			value_q <= dec_val;
			byte_q  <= '0;
			len_q   <= dec_len;
			last_q  <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign decoded_value = value_q;
	assign encoded_byte  = byte_q;
	assign length        = len_q;
	assign last          = last_q;

endmodule

// File: tb/leb128_codec_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb128_codec_tb
// Self-checking bench for the LEB128 codec. A queue of pending items feeds a
// valid/ready driver; every accepted item runs through a cycle-free codec
// predictor whose expected results are compared field by field with what
// the block emits. Directed corner cases come first, then random well-formed
// byte sequences and encode words with some noise, random idling on both
// sides and a drain pause.
// ----------------------------------------------------------------------------
module leb128_codec_tb;
	import lebc_pkg::*;

	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam int         IDLE_PCT   = 17;
	localparam int         CALM_FROM  = 300;
	localparam int         CALM_TO    = 700;
	localparam int         STALL_MAX  = 2000;
	localparam int         TAIL_WAIT  = 20;
	localparam int         ITEM_COUNT = 460;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  dbyte;
		logic [31:0] wval;
		logic        drain;
	} stim_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] value;
		logic [7:0]  ebyte;
		logic [2:0]  len;
		logic        last;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  operation = OP_DEC_U;
	logic [7:0]  data_byte = 8'd0;
	logic [31:0] word = 32'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        kind;
	logic [31:0] decoded_value;
	logic [7:0]  encoded_byte;
	logic [2:0]  length;
	logic        last;

	stim_t   pending_q[$];
	result_t expected_q[$];

	// predictor copy of the decode state
	logic [31:0] acc_pred = 32'd0;
	logic [2:0]  seen_pred = 3'd0;
	logic        signed_pred = 1'b0;

	int  fail_count = 0;
	int  live_items = 0;
	int  cyc = 0;
	int  stall_cnt = 0;
	bit  hold_next = 1'b0;
	logic calm;

	assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

	leb128_codec DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.data_byte     (data_byte),
		.word          (word),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.decoded_value (decoded_value),
		.encoded_byte  (encoded_byte),
		.length        (length),
		.last          (last)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] mismatch %s: got 0x%08h want 0x%08h", $realtime, what, got, want);
		fail_count++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// codec predictor: one accepted item in, its results onto expected_q
	task automatic predict_codec(input logic [1:0] op, input logic [7:0] b,
			input logic [31:0] w);
		result_t     r;
		logic [31:0] rest;
		logic [31:0] msk;
		logic [2:0]  n;
		logic        fin;
		if (op == OP_DEC_U || op == OP_DEC_S) begin
			if (seen_pred == 3'd0)
				signed_pred = (op == OP_DEC_S);
			// fifth byte closes the value, only its low nibble survives
			if (seen_pred >= LAST_IDX) begin
				acc_pred = acc_pred | {b[3:0], 28'd0};
				n = MAX_BYTES;
				fin = 1'b1;
			end else begin
				acc_pred = acc_pred | ({25'd0, b[6:0]} << (7 * seen_pred));
				n = seen_pred + 3'd1;
				fin = !b[7];
			end
			if (!fin) begin
				seen_pred = n;
			end else begin
				r.value = acc_pred;
				// sign extension from the top group bit
				if (signed_pred && n < MAX_BYTES) begin
					msk = 32'd1 << (7 * n - 1);
					r.value = (r.value ^ msk) - msk;
				end
				r.kind = KIND_VALUE;
				r.ebyte = 8'd0;
				r.len = n;
				r.last = 1'b1;
				expected_q.insert(expected_q.size(), r);
				acc_pred = 32'd0;
				seen_pred = 3'd0;
			end
		end else if (op == OP_ENC) begin
			rest = w;
			do begin
				r.kind = KIND_BYTE;
				r.value = 32'd0;
				r.len = 3'd0;
				r.ebyte = {1'b0, rest[6:0]};
				rest = rest >> 7;
				r.last = (rest == 32'd0);
				if (rest != 32'd0)
					r.ebyte = r.ebyte | CONT_BIT;
				expected_q.insert(expected_q.size(), r);
			end while (rest != 32'd0);
		end
	endtask

	task automatic add_item(input logic [1:0] op, input logic [7:0] b, input logic [31:0] w);
		stim_t s;
		s.op = op;
		s.dbyte = b;
		s.wval = w;
		s.drain = hold_next;
		hold_next = 1'b0;
		pending_q.insert(pending_q.size(), s);
		if (op != OP_UNUSED)
			live_items++;
	endtask

	// one random burst: an encode word, a decode sequence or a noise item
	task automatic add_random_burst();
		int          pick;
		int          nb;
		logic [1:0]  seq_op;
		logic [1:0]  byte_op;
		logic [7:0]  b;
		pick = $urandom_range(99);
		if (pick < 40) begin
			add_item(OP_ENC, 8'($urandom), $urandom >> $urandom_range(31));
		end else if (pick < 85) begin
			seq_op = $urandom_range(1) ? OP_DEC_S : OP_DEC_U;
			nb = $urandom_range(5, 1);
			for (int i = 0; i < nb; i++) begin
				b = 8'($urandom);
				if (i < nb - 1)
					b[7] = 1'b1;
				else if (nb < 5)
					b[7] = 1'b0;
				// later bytes sometimes carry the other decode code
				byte_op = seq_op;
				if (i > 0 && $urandom_range(9) == 0)
					byte_op = (seq_op == OP_DEC_S) ? OP_DEC_U : OP_DEC_S;
				add_item(byte_op, b, $urandom);
				// encode or unused item slipped into the sequence
				if (i < nb - 1 && $urandom_range(9) == 0)
					add_item($urandom_range(1) ? OP_ENC : OP_UNUSED, 8'($urandom), $urandom);
			end
		end else begin
			add_item(2'($urandom_range(3)), 8'($urandom), $urandom);
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin : drive
		stim_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				predict_codec(operation, data_byte, word);
			if (!in_valid || in_ready) begin
				if (pending_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)
						&& !(pending_q[0].drain && expected_q.size() != 0)) begin
					nxt = pending_q.pop_front();
					in_valid <= 1'b1;
					operation <= nxt.op;
					data_byte <= nxt.dbyte;
					word <= nxt.wval;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin : monitor
		result_t want_r;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected result, decoded_value", decoded_value, 32'd0);
				end else begin
					want_r = expected_q.pop_front();
					check_field("kind", 32'(kind), 32'(want_r.kind));
					check_field("decoded_value", decoded_value, want_r.value);
					check_field("encoded_byte", 32'(encoded_byte), 32'(want_r.ebyte));
					check_field("length", 32'(length), 32'(want_r.len));
					check_field("last", 32'(last), 32'(want_r.last));
				end
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cnt <= 0;
		end else begin
			cyc <= cyc + 1;
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cnt <= 0;
			else
				stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_MAX) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// stimulus and end of run
	initial begin
		// single-byte values, unsigned and signed extremes
		add_item(OP_DEC_U, 8'h00, 32'd0);
		add_item(OP_DEC_U, 8'h7f, 32'd0);
		add_item(OP_DEC_S, 8'h7f, 32'd0);
		add_item(OP_DEC_S, 8'h40, 32'd0);
		// two-byte unsigned
		add_item(OP_DEC_U, 8'hff, 32'd0);
		add_item(OP_DEC_U, 8'h7f, 32'd0);
		// five-byte value with high bits on the fifth byte
		add_item(OP_DEC_U, 8'hff, 32'd0);
		add_item(OP_DEC_U, 8'hff, 32'd0);
		add_item(OP_DEC_U, 8'hff, 32'd0);
		add_item(OP_DEC_U, 8'hff, 32'd0);
		add_item(OP_DEC_U, 8'hf7, 32'd0);
		// signedness comes from the first byte only
		add_item(OP_DEC_S, 8'hff, 32'd0);
		add_item(OP_DEC_U, 8'h7f, 32'd0);
		// encode extremes and group boundaries
		add_item(OP_ENC, 8'h00, 32'h0000_0000);
		add_item(OP_ENC, 8'hff, 32'hffff_ffff);
		add_item(OP_ENC, 8'h00, 32'h0000_007f);
		add_item(OP_ENC, 8'h00, 32'h0000_0080);
		// unused code on its own
		add_item(OP_UNUSED, 8'hff, 32'hffff_ffff);
		// encode and unused code in the middle of a decode
		add_item(OP_DEC_S, 8'h80, 32'd0);
		add_item(OP_ENC, 8'h00, 32'd300);
		add_item(OP_UNUSED, 8'h00, 32'd0);
		add_item(OP_DEC_S, 8'h01, 32'd0);

		hold_next = 1'b1;
		live_items = 0;
		while (live_items < ITEM_COUNT) begin
			if ($urandom_range(49) == 0)
				hold_next = 1'b1;
			add_random_burst();
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_q.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		if (fail_count == 0 && expected_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
